@@ src/kdlp_pkg.sv @@
// shared constants and types for the keypad debounce and long-press block
package kdlp_pkg;

  // matrix geometry
  localparam int ROWS     = 6;
  localparam int COLS     = 5;
  localparam int MAX_POS  = 30;
  localparam int NPOS     = (ROWS * COLS < MAX_POS) ? ROWS * COLS : MAX_POS;

  // field widths
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 4;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

  // configuration reset values
  localparam logic [MAX_POS-1:0] MASK_RESET      = 30'd16252927;
  localparam logic [CNT_W-1:0]   THRESHOLD_RESET = 4'd3;
  localparam logic [TIME_W-1:0]  LONG_RESET      = 32'd1000;

  // input command codes
  localparam logic CMD_SCAN   = 1'b0;
  localparam logic CMD_INJECT = 1'b1;

  // what the merge stage found across all lanes
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } merge_t;

endpackage

@@ src/kdlp_lane.sv @@
// one debounce lane: saturating up/down counter for a single key position
module kdlp_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        raw_i,
  input  logic                        mask_i,
  input  logic [kdlp_pkg::CNT_W-1:0]  thr_i,
  output logic                        det_o
);

  logic [kdlp_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_upd;

  // count up toward threshold while pressed, down toward zero while released
  always_comb begin
    cnt_upd = cnt_q;
    if (raw_i) begin
      if (cnt_q < thr_i) cnt_upd = cnt_q + 1'b1;
    end else if (cnt_q != '0) begin
      cnt_upd = cnt_q - 1'b1;
    end
    cnt_d = en_i ? cnt_upd : cnt_q;
  end

  // debounced pressed after this sample
  assign det_o = (cnt_upd >= thr_i) && mask_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ src/kdlp_merge.sv @@
// merge stage: picks the highest debounced position over all lanes
module kdlp_merge (
  input  logic [kdlp_pkg::NPOS-1:0] det_i,
  output kdlp_pkg::merge_t          res_o
);

  // later positions override earlier ones, so the highest wins
  always_comb begin
    res_o.found = 1'b0;
    res_o.idx   = '0;
    for (int p = 0; p < kdlp_pkg::NPOS; p++) begin
      if (det_i[p]) begin
        res_o.found = 1'b1;
        res_o.idx   = kdlp_pkg::IDX_W'(p);
      end
    end
  end

endmodule

@@ src/keypad_debounce_long_press_top.sv @@
// top level of the keypad debounce and long-press detector
// Each request carries one full matrix sample (or a virtual key injection) and
// the current millisecond time, and yields exactly one result: an optional
// press or long-press event plus the held key and the time of the last press.
// One request is taken per clock cycle unless stalled; the result is registered
// in the output register in the cycle after acceptance. All key positions have
// their own debounce counter and update in the same cycle, and one priority
// stage picks the highest debounced position. The output register frees itself
// when its result is taken, so a new request is accepted in the same cycle.
module keypad_debounce_long_press_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kdlp_pkg::CFG_W-1:0]          cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [kdlp_pkg::MAX_POS-1:0]        pressed_bits_i,
  input  logic [kdlp_pkg::TIME_W-1:0]         now_ms_i,
  input  logic [kdlp_pkg::IDX_W-1:0]          inject_index_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                event_valid_o,
  output logic [kdlp_pkg::IDX_W-1:0]          event_key_o,
  output logic                                event_long_o,
  output logic                                key_held_o,
  output logic [kdlp_pkg::IDX_W-1:0]          held_key_o,
  output logic [kdlp_pkg::TIME_W-1:0]         last_press_time_o
);

  // configuration registers
  logic [kdlp_pkg::MAX_POS-1:0] mask_q;
  logic [kdlp_pkg::CNT_W-1:0]   thr_q;
  logic [kdlp_pkg::TIME_W-1:0]  long_q;

  // key tracking state
  logic                         held_q, held_d;
  logic [kdlp_pkg::IDX_W-1:0]   held_idx_q, held_idx_d;
  logic [kdlp_pkg::TIME_W-1:0]  start_q, start_d;
  logic [kdlp_pkg::TIME_W-1:0]  last_q, last_d;
  logic                         long_sent_q, long_sent_d;

  // output register
  logic                         out_valid_q;
  logic                         ev_valid_q, ev_long_q;
  logic [kdlp_pkg::IDX_W-1:0]   ev_key_q;
  logic                         ev_valid_d, ev_long_d;
  logic [kdlp_pkg::IDX_W-1:0]   ev_key_d;

  logic                         accept;
  logic                         scan_en;
  logic [kdlp_pkg::NPOS-1:0]    det;
  kdlp_pkg::merge_t             merged;
  logic [kdlp_pkg::TIME_W-1:0]  held_for;
  logic [31:0]                  mask_ext;
  logic                         inj_ok;

  // handshake: accept whenever the output slot is empty or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_en    = accept && (cmd_i == kdlp_pkg::CMD_SCAN);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= kdlp_pkg::MASK_RESET;
      thr_q  <= kdlp_pkg::THRESHOLD_RESET;
      long_q <= kdlp_pkg::LONG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kdlp_pkg::REG_VALID_MASK: mask_q <= cfg_data_i[kdlp_pkg::MAX_POS-1:0];
        kdlp_pkg::REG_THRESHOLD:  thr_q  <= cfg_data_i[kdlp_pkg::CNT_W-1:0];
        kdlp_pkg::REG_LONG_PRESS: long_q <= cfg_data_i[kdlp_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // one debounce lane per scanned position
  for (genvar g = 0; g < kdlp_pkg::NPOS; g++) begin : g_lane
    kdlp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (scan_en),
      .raw_i  (pressed_bits_i[g]),
      .mask_i (mask_q[g]),
      .thr_i  (thr_q),
      .det_o  (det[g])
    );
  end

  // highest debounced key
  kdlp_merge u_merge (
    .det_i (det),
    .res_o (merged)
  );

  // injection check
  assign mask_ext = 32'(mask_q);
  assign inj_ok   = ({1'b0, inject_index_i} < 6'(kdlp_pkg::NPOS))
                    && mask_ext[inject_index_i];
  assign held_for = now_ms_i - start_q;

  // event decision and next tracking state
  always_comb begin
    held_d      = held_q;
    held_idx_d  = held_idx_q;
    start_d     = start_q;
    last_d      = last_q;
    long_sent_d = long_sent_q;
    ev_valid_d  = 1'b0;
    ev_key_d    = '0;
    ev_long_d   = 1'b0;
    if (cmd_i == kdlp_pkg::CMD_INJECT) begin
      if (inj_ok) begin
        start_d     = now_ms_i;
        last_d      = now_ms_i;
        long_sent_d = 1'b0;
        ev_valid_d  = 1'b1;
        ev_key_d    = inject_index_i;
        held_d      = 1'b0;
        held_idx_d  = '0;
      end
    end else if (merged.found) begin
      if (!held_q || (merged.idx != held_idx_q)) begin
        held_d      = 1'b1;
        held_idx_d  = merged.idx;
        start_d     = now_ms_i;
        long_sent_d = 1'b0;
        last_d      = now_ms_i;
        ev_valid_d  = 1'b1;
        ev_key_d    = merged.idx;
      end else if (!long_sent_q && (held_for >= long_q)) begin
        long_sent_d = 1'b1;
        ev_valid_d  = 1'b1;
        ev_key_d    = held_idx_q;
        ev_long_d   = 1'b1;
      end
    end else begin
      held_d     = 1'b0;
      held_idx_d = '0;
    end
  end

  // tracking state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_idx_q  <= '0;
      start_q     <= '0;
      last_q      <= '0;
      long_sent_q <= 1'b0;
    end else if (accept) begin
      held_q      <= held_d;
      held_idx_q  <= held_idx_d;
      start_q     <= start_d;
      last_q      <= last_d;
      long_sent_q <= long_sent_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_valid_q <= ev_valid_d;
      ev_key_q   <= ev_key_d;
      ev_long_q  <= ev_long_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_valid_o     = ev_valid_q;
  assign event_key_o       = ev_key_q;
  assign event_long_o      = ev_long_q;
  assign key_held_o        = held_q;
  assign held_key_o        = held_idx_q;
  assign last_press_time_o = last_q;

endmodule
